>>> sv/cwss_pkg.sv
// Shared types and constants for the corridor width smooth and seal block.
package cwss_pkg;

    localparam int unsigned DEF_MAX_SAMPLES   = 64;
    localparam int unsigned DEF_SMOOTH_PASSES = 2;

    localparam int unsigned WIDTH_W = 16;
    localparam int unsigned LAYER_W = 4;
    localparam int unsigned PAIR_W  = 2 * WIDTH_W;
    localparam int unsigned CFG_W   = 4;

    localparam logic CFG_SEAL_LENGTH  = 1'b0;
    localparam logic CFG_GROUND_LAYER = 1'b1;

    localparam logic [CFG_W-1:0] SEAL_RESET   = 4'd3;
    localparam logic [CFG_W-1:0] GROUND_RESET = 4'd1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SMOOTH,
        ST_FWD,
        ST_BWD,
        ST_EMIT
    } t_state;

    typedef logic [PAIR_W-1:0] t_pair;

endpackage

>>> sv/cwss_mem.sv
// Profile memory: width pairs and layer ids, one write and one registered read port.
module cwss_mem #(
    parameter int unsigned MAX_SAMPLES = cwss_pkg::DEF_MAX_SAMPLES
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic                                i_layer_we,
    input  logic [$clog2(MAX_SAMPLES)-1:0]      i_waddr,
    input  cwss_pkg::t_pair                     i_wdata,
    input  logic [cwss_pkg::LAYER_W-1:0]        i_wlayer,
    input  logic                                i_re,
    input  logic [$clog2(MAX_SAMPLES)-1:0]      i_raddr,
    output cwss_pkg::t_pair                     o_rdata,
    output logic [cwss_pkg::LAYER_W-1:0]        o_rlayer
);
    import cwss_pkg::*;

    t_pair              r_pair_mem  [MAX_SAMPLES];
    logic [LAYER_W-1:0] r_layer_mem [MAX_SAMPLES];
    t_pair              r_rdata;
    logic [LAYER_W-1:0] r_rlayer;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pair_mem[i_waddr] <= i_wdata;
        end
        if (i_layer_we) begin
            r_layer_mem[i_waddr] <= i_wlayer;
        end
        if (i_re) begin
            r_rdata  <= r_pair_mem[i_raddr];
            r_rlayer <= r_layer_mem[i_raddr];
        end
    end

    assign o_rdata  = r_rdata;
    assign o_rlayer = r_rlayer;

endmodule

>>> sv/corridor_width_smooth_seal.sv
// Top level: profile loader, in-memory smoothing and sealing walks, result emitter.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: left, right, layer; tlast: last sample
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: left, right; tuser: too_short; tlast
//  cfg       in   i_cfg_valid/o_cfg_ready        index, 4-bit data
//
//  Samples load at one per cycle unless a too-short result waits. On the last
//  sample, if there are two or more, each smoothing pass and each sealing sweep
//  walks the memory read port; the emitter reads one result at a time. Input is
//  held off from the last sample until the final result is taken. Synchronous
//  active-low reset empties the profile and restores the register defaults.
module corridor_width_smooth_seal #(
    parameter int unsigned MAX_SAMPLES   = cwss_pkg::DEF_MAX_SAMPLES,
    parameter int unsigned SMOOTH_PASSES = cwss_pkg::DEF_SMOOTH_PASSES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [39:0]                   s_axis_tdata,  // left[15:0], right[31:16], layer[35:32]
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // left_out[15:0], right_out[31:16]
    output logic                          m_axis_tuser,  // too_short[0]
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [cwss_pkg::CFG_W-1:0]    i_cfg_data
);
    import cwss_pkg::*;

    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned PW = $clog2(SMOOTH_PASSES) + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);
    localparam logic [PW-1:0] LAST_PASS = PW'(SMOOTH_PASSES - 1);

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_seal, r_ground;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_idx, n_idx;
    logic [PW-1:0]      r_pass, n_pass;
    logic               r_rd_vld, n_rd_vld;
    logic [AW-1:0]      r_rd_addr, n_rd_addr;
    logic               r_flush, n_flush;
    t_pair              r_p, n_p, r_c, n_c;
    logic [LAYER_W-1:0] r_pl, n_pl, r_cl, n_cl;
    logic               r_prev_deck, n_prev_deck;
    logic [CFG_W-1:0]   r_hold_cnt, n_hold_cnt;
    t_pair              r_hold, n_hold;
    logic               r_ov, n_ov;
    t_pair              r_od, n_od;
    logic               r_ouser, n_ouser, r_olast, n_olast;

    logic               in_fire, out_fire;
    logic               mem_we, mem_layer_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    t_pair              mem_wdata, rd_data;
    logic [LAYER_W-1:0] rd_layer;
    logic               issue_done, walk_done;
    logic [CW-1:0]      count_inc;
    t_pair              sm_p, sm_q, sm_out;
    logic               deck;
    logic [CFG_W-1:0]   eff_cnt;

    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_fire      = r_ov & m_axis_tready;
    assign s_axis_tready = (r_state == ST_LOAD) & ~r_ov;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    assign issue_done = (r_idx == r_n);
    assign walk_done  = (r_state == ST_SMOOTH) ? r_flush : (issue_done & ~r_rd_vld);
    assign count_inc  = (r_count < MAX_CNT) ? r_count + CW'(1) : r_count;
    assign deck       = rd_layer > r_ground;
    assign eff_cnt    = r_prev_deck ? r_seal : r_hold_cnt;

    function automatic t_pair tap3(t_pair a, t_pair c, t_pair b);
        logic [WIDTH_W+1:0] sl, sr;
        sl = {2'b0, a[WIDTH_W-1:0]} + {1'b0, c[WIDTH_W-1:0], 1'b0} + {2'b0, b[WIDTH_W-1:0]};
        sr = {2'b0, a[PAIR_W-1:WIDTH_W]} + {1'b0, c[PAIR_W-1:WIDTH_W], 1'b0}
           + {2'b0, b[PAIR_W-1:WIDTH_W]};
        return {sr[WIDTH_W+1:2], sl[WIDTH_W+1:2]};
    endfunction

    function automatic t_pair pair_min(t_pair a, t_pair b);
        logic [WIDTH_W-1:0] l, r;
        l = (a[WIDTH_W-1:0] > b[WIDTH_W-1:0]) ? b[WIDTH_W-1:0] : a[WIDTH_W-1:0];
        r = (a[PAIR_W-1:WIDTH_W] > b[PAIR_W-1:WIDTH_W]) ?
            b[PAIR_W-1:WIDTH_W] : a[PAIR_W-1:WIDTH_W];
        return {r, l};
    endfunction

    always_comb begin
        if (r_flush) begin
            sm_p = (r_pl == r_cl) ? r_p : r_c;
            sm_q = r_c;
        end else begin
            sm_p = (r_pl == r_cl) ? r_p : r_c;
            sm_q = (rd_layer == r_cl) ? rd_data : r_c;
        end
        sm_out = tap3(sm_p, r_c, sm_q);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_fire && s_axis_tlast && count_inc >= CW'(2)) begin
                    n_state = ST_SMOOTH;
                end
            end
            ST_SMOOTH: begin
                if (walk_done && r_pass == LAST_PASS) begin
                    n_state = ST_FWD;
                end
            end
            ST_FWD: begin
                if (walk_done) begin
                    n_state = ST_BWD;
                end
            end
            ST_BWD: begin
                if (walk_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (walk_done) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_n         = r_n;
        n_idx       = r_idx;
        n_pass      = r_pass;
        n_rd_vld    = 1'b0;
        n_rd_addr   = r_rd_addr;
        n_flush     = 1'b0;
        n_p         = r_p;
        n_c         = r_c;
        n_pl        = r_pl;
        n_cl        = r_cl;
        n_prev_deck = r_prev_deck;
        n_hold_cnt  = r_hold_cnt;
        n_hold      = r_hold;
        n_ov        = out_fire ? 1'b0 : r_ov;
        n_od        = r_od;
        n_ouser     = r_ouser;
        n_olast     = r_olast;
        mem_we       = 1'b0;
        mem_layer_we = 1'b0;
        mem_waddr    = r_count[AW-1:0];
        mem_wdata    = s_axis_tdata[PAIR_W-1:0];
        mem_re       = 1'b0;
        mem_raddr    = r_idx[AW-1:0];

        unique case (r_state)
            ST_LOAD: begin
                if (in_fire) begin
                    if (r_count < MAX_CNT) begin
                        mem_we       = 1'b1;
                        mem_layer_we = 1'b1;
                    end
                    n_count = count_inc;
                    if (s_axis_tlast) begin
                        n_count = '0;
                        n_n     = count_inc;
                        n_idx   = '0;
                        n_pass  = '0;
                        if (count_inc < CW'(2)) begin
                            n_ov    = 1'b1;
                            n_od    = '0;
                            n_ouser = 1'b1;
                            n_olast = 1'b1;
                        end
                    end
                end
            end
            ST_SMOOTH: begin
                if (!issue_done) begin
                    mem_re = 1'b1;
                    n_idx  = r_idx + CW'(1);
                end
                n_rd_vld  = ~issue_done;
                n_rd_addr = r_idx[AW-1:0];
                if (r_rd_vld) begin
                    if (r_rd_addr == '0) begin
                        n_p  = rd_data;
                        n_pl = rd_layer;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_rd_addr - AW'(1);
                        mem_wdata = sm_out;
                        n_p       = r_c;
                        n_pl      = r_cl;
                    end
                    n_c     = rd_data;
                    n_cl    = rd_layer;
                    n_flush = (r_rd_addr == AW'(r_n - CW'(1)));
                end
                if (r_flush) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_n - CW'(1));
                    mem_wdata = sm_out;
                    n_idx     = '0;
                    n_pass    = r_pass + PW'(1);
                    n_prev_deck = 1'b0;
                    n_hold_cnt  = '0;
                end
            end
            ST_FWD, ST_BWD: begin
                if (!issue_done) begin
                    mem_re = 1'b1;
                    n_idx  = r_idx + CW'(1);
                end
                if (r_state == ST_BWD) begin
                    mem_raddr = AW'(r_n - CW'(1) - r_idx);
                end
                n_rd_vld  = ~issue_done;
                n_rd_addr = mem_raddr;
                if (r_rd_vld) begin
                    mem_waddr = r_rd_addr;
                    if (deck) begin
                        n_hold      = rd_data;
                        n_hold_cnt  = '0;
                        n_prev_deck = 1'b1;
                    end else begin
                        n_prev_deck = 1'b0;
                        if (eff_cnt != '0) begin
                            mem_we     = 1'b1;
                            mem_wdata  = pair_min(rd_data, r_hold);
                            n_hold_cnt = eff_cnt - CFG_W'(1);
                        end else begin
                            n_hold_cnt = '0;
                        end
                    end
                end
                if (walk_done) begin
                    n_idx       = '0;
                    n_prev_deck = 1'b0;
                    n_hold_cnt  = '0;
                end
            end
            ST_EMIT: begin
                if (!issue_done && !r_rd_vld && (!r_ov || out_fire)) begin
                    mem_re   = 1'b1;
                    n_idx    = r_idx + CW'(1);
                    n_rd_vld = 1'b1;
                end
                n_rd_addr = r_idx[AW-1:0];
                if (r_rd_vld) begin
                    n_ov    = 1'b1;
                    n_od    = rd_data;
                    n_ouser = 1'b0;
                    n_olast = (r_rd_addr == AW'(r_n - CW'(1)));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_seal      <= SEAL_RESET;
            r_ground    <= GROUND_RESET;
            r_count     <= '0;
            r_n         <= '0;
            r_idx       <= '0;
            r_pass      <= '0;
            r_rd_vld    <= 1'b0;
            r_flush     <= 1'b0;
            r_prev_deck <= 1'b0;
            r_hold_cnt  <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_n         <= n_n;
            r_idx       <= n_idx;
            r_pass      <= n_pass;
            r_rd_vld    <= n_rd_vld;
            r_flush     <= n_flush;
            r_prev_deck <= n_prev_deck;
            r_hold_cnt  <= n_hold_cnt;
            r_ov        <= n_ov;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SEAL_LENGTH:  r_seal   <= i_cfg_data;
                    CFG_GROUND_LAYER: r_ground <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_p       <= n_p;
        r_c       <= n_c;
        r_pl      <= n_pl;
        r_cl      <= n_cl;
        r_hold    <= n_hold;
        r_od      <= n_od;
        r_ouser   <= n_ouser;
        r_olast   <= n_olast;
    end

    cwss_mem #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_mem (
        .i_clk      (i_clk),
        .i_we       (mem_we),
        .i_layer_we (mem_layer_we),
        .i_waddr    (mem_waddr),
        .i_wdata    (mem_wdata),
        .i_wlayer   (s_axis_tdata[PAIR_W+LAYER_W-1:PAIR_W]),
        .i_re       (mem_re),
        .i_raddr    (mem_raddr),
        .o_rdata    (rd_data),
        .o_rlayer   (rd_layer)
    );

endmodule
